// ----- hdl/mdfr_pkg.sv -----
// Shared constants, types and elaboration-time table builders for the duty fade ramp block.
package mdfr_pkg;

    // Fixed field and format widths
    localparam int TIME_W        = 32;
    localparam int DUTY_FRAC_W   = 16;
    localparam int CFG_DATA_W    = 16;
    localparam int MODE_W        = 2;

    // Defaults for the top-level parameters
    localparam int DEF_CHANNELS   = 6;
    localparam int DEF_DUTY_BITS  = 12;
    localparam int DEF_DEMO_DEPTH = 256;

    // Ramp timing
    localparam int unsigned FULL_SCALE  = 65535;
    localparam int unsigned STEP_MIN_MS = 10;
    localparam int unsigned SLEW_PER_S  = 4;
    localparam int unsigned MS_PER_S    = 1000;

    // Step size lookup covers elapsed times below 256 ms; anything longer saturates
    localparam int STEP_IDX_W     = 8;
    localparam int STEP_TBL_DEPTH = 1 << STEP_IDX_W;

    // Breathing curve period and the serial divider that reduces time by it
    localparam int unsigned DEMO_PERIOD_MS = 2500;
    localparam int REM_W          = $clog2(DEMO_PERIOD_MS);
    localparam int DIV_STEP_BITS  = 4;

    // Register indexes
    localparam int REG_MODE    = 0;
    localparam int REG_TARGET0 = 1;

    // Mode codes
    localparam logic [MODE_W-1:0] MODE_FADE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DEMO   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FOLLOW = 2'd2;

    // Q30 constants for the curve builder
    localparam logic [63:0] Q_ONE  = 64'd1 << 30;
    localparam logic [63:0] ONE_60 = 64'd1 << 60;
    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_CALC,
        S_MUL,
        S_CODE,
        S_FLUSH,
        S_MOD_RUN,
        S_SCALE,
        S_QUO_RUN,
        S_ROM,
        S_DEMO_WR
    } state_t;

    // Per-channel timer entry
    typedef struct packed {
        logic              started;
        logic [TIME_W-1:0] start;
    } time_entry_t;

    // Long division, only evaluated while building constant tables
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // exp(x) in Q30, 0 <= x <= 1
    function automatic logic [63:0] exp_q30(input logic [63:0] x);
        logic [63:0] sum;
        logic [63:0] term;
        sum  = Q_ONE;
        term = Q_ONE;
        for (int k = 1; k <= 16; k++) begin
            term = udiv64((term * x) >> 30, 64'(k));
            sum  = sum + term;
        end
        return sum;
    endfunction

    // cos(a) in Q30 on a quarter wave, clamped to 0..1
    function automatic logic [63:0] cos_q30(input logic [63:0] a);
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        x2   = (a * a) >> 30;
        term = Q_ONE;
        sum  = longint'(Q_ONE);
        for (int k = 1; k <= 10; k++) begin
            term = udiv64((term * x2) >> 30, 64'((2 * k - 1) * (2 * k)));
            if (k[0]) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > longint'(Q_ONE)) begin
            sum = longint'(Q_ONE);
        end
        return 64'(sum);
    endfunction

    // One entry of the normalized exp(cos) breathing curve
    function automatic logic [15:0] demo_entry(input int i, input int depth);
        logic [63:0] e1;
        logic [63:0] einv;
        logic [63:0] span;
        logic [63:0] j;
        logic [63:0] dep;
        logic [63:0] ang;
        logic [63:0] c;
        logic [63:0] ev;
        logic [63:0] v;
        logic        neg;
        dep  = 64'(depth);
        j    = 64'(i);
        neg  = 1'b0;
        e1   = exp_q30(Q_ONE);
        einv = udiv64(ONE_60, e1);
        span = e1 - einv;
        if (2 * j > dep) begin
            j = dep - j;
        end
        ang = udiv64(PI_Q30 * 64'd2 * j, dep);
        if (ang > (PI_Q30 >> 1)) begin
            ang = PI_Q30 - ang;
            neg = 1'b1;
        end
        c  = cos_q30(ang);
        ev = exp_q30(c);
        if (neg) begin
            ev = udiv64(ONE_60, ev);
        end
        if (ev <= einv) begin
            v = '0;
        end else begin
            v = udiv64((ev - einv) * 64'(FULL_SCALE) + (span >> 1), span);
        end
        if (v > 64'(FULL_SCALE)) begin
            v = 64'(FULL_SCALE);
        end
        return v[15:0];
    endfunction

    // Duty step for an elapsed time below the table depth
    function automatic logic [15:0] step_entry(input int i);
        logic [63:0] v;
        if (i < int'(STEP_MIN_MS)) begin
            v = '0;
        end else begin
            v = 64'(i) * 64'(SLEW_PER_S) * 64'(FULL_SCALE) / MS_PER_S;
        end
        if (v > 64'(FULL_SCALE)) begin
            v = 64'(FULL_SCALE);
        end
        return v[15:0];
    endfunction

endpackage

// ----- hdl/mdfr_div.sv -----
// Serial divider by the breathing period: four quotient bits per cycle.
module mdfr_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [mdfr_pkg::TIME_W-1:0]  num,
    output logic                         done,
    output logic [mdfr_pkg::TIME_W-1:0]  quo,
    output logic [mdfr_pkg::REM_W-1:0]   rem
);

    localparam int NW    = mdfr_pkg::TIME_W;
    localparam int RW    = mdfr_pkg::REM_W;
    localparam int SB    = mdfr_pkg::DIV_STEP_BITS;
    localparam int STEPS = NW / SB;
    localparam int CNT_W = $clog2(STEPS);
    localparam logic [RW:0] DIVISOR = (RW + 1)'(mdfr_pkg::DEMO_PERIOD_MS);

    logic [NW-1:0]    num_reg;
    logic [NW-1:0]    quo_reg;
    logic [RW-1:0]    rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [RW-1:0]    r_c;
    logic [RW:0]      r_ext_c;
    logic [SB-1:0]    q_c;

    // Restoring steps: remainder stays below the divisor, so one subtract each
    always_comb begin
        r_c     = rem_reg;
        r_ext_c = '0;
        q_c     = '0;
        for (int b = 0; b < SB; b++) begin
            r_ext_c = {r_c, num_reg[NW-1-b]};
            if (r_ext_c >= DIVISOR) begin
                r_c          = RW'(r_ext_c - DIVISOR);
                q_c[SB-1-b]  = 1'b1;
            end else begin
                r_c = r_ext_c[RW-1:0];
            end
        end
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= num;
            quo_reg <= '0;
            rem_reg <= '0;
        end else if (busy_reg) begin
            num_reg <= num_reg << SB;
            quo_reg <= {quo_reg[NW-SB-1:0], q_c};
            rem_reg <= r_c;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

// ----- hdl/mdfr_demo_rom.sv -----
// Breathing curve ROM, built at elaboration, with a registered read.
module mdfr_demo_rom #(
    parameter int DEPTH = mdfr_pkg::DEF_DEMO_DEPTH
) (
    input  logic                     aclk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] idx,
    output logic [15:0]              rd_data
);

    logic [15:0] rom [DEPTH];
    logic [15:0] rd_data_reg;

    // Curve entries
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_rom
        localparam logic [15:0] ENTRY = mdfr_pkg::demo_entry(gi, DEPTH);
        assign rom[gi] = ENTRY;
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= rom[idx];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/multichannel_duty_fade_ramp_top.sv -----
// Top level of the multichannel PWM duty fade ramp: sequencer, state memories, output stage.
//
// Usage:
//   s_ channel: one transfer per time tick, s_tdata carries now_ms (ms, wraps at 2^32).
//   m_ channel: one transfer per changed channel, or one per tick in demo mode, with its PWM compare code;
//     m_tlast marks the final transfer caused by a tick. A tick may cause none.
//   cfg port: mode (index 0) and per-channel targets (index 1..CHANNELS), written
//     while the block is idle.
// Throughput: one tick at a time. Fade and follow modes walk the channels through the
//   duty and timer memories: each channel is read, then modified and written back, and
//   each changed channel also passes through code scaling. Demo mode runs two passes
//   of the 4-bit-per-cycle divide by 2500 and one ROM read.
// Path: each result is registered through the new duty, product and hold stages before the
//   output register; the last result of a tick is held in the hold stage so it can carry m_tlast.
// Reset: aresetn (synchronous, active low) clears mode, targets, all channel duties,
//   start times and started flags (through per-entry valid bits), and empties outputs.
// Stall: results wait in the output register and one hold stage; the sequencer pauses
//   when both are full and resumes when m_tready returns. s_tready is high only
//   between ticks.
module multichannel_duty_fade_ramp_top #(
    parameter int CHANNELS         = mdfr_pkg::DEF_CHANNELS,
    parameter int DUTY_BITS        = mdfr_pkg::DEF_DUTY_BITS,
    parameter int DEMO_TABLE_DEPTH = mdfr_pkg::DEF_DEMO_DEPTH,
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
    localparam int CFG_AW = $clog2(CHANNELS + 1),
    localparam int OUT_TW = ((CH_W + DUTY_BITS + 7) / 8) * 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Tick input; s_tdata: [31:0] now_ms
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [mdfr_pkg::TIME_W-1:0]       s_tdata,
    // Results; m_tdata: [CH_W-1:0] channel, then duty_code, zero padded
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [OUT_TW-1:0]                 m_tdata,
    output logic                              m_tlast,
    // Register writes
    input  logic                              cfg_wr_en,
    input  logic [CFG_AW-1:0]                 cfg_addr,
    input  logic [mdfr_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int TW     = mdfr_pkg::TIME_W;
    localparam int FW     = mdfr_pkg::DUTY_FRAC_W;
    localparam int IDX_W  = $clog2(DEMO_TABLE_DEPTH);
    localparam int PW     = FW + DUTY_BITS;
    localparam int SIW    = mdfr_pkg::STEP_IDX_W;
    localparam logic [PW-1:0] DUTY_MAX = PW'((1 << DUTY_BITS) - 1);
    localparam logic [FW-1:0] FULL     = FW'(mdfr_pkg::FULL_SCALE);

    // ---------------- state ----------------
    mdfr_pkg::state_t state_reg, state_next;

    logic [mdfr_pkg::MODE_W-1:0] mode_reg;
    logic [FW-1:0]               target_reg [CHANNELS];

    logic [CH_W-1:0]             ch_reg;
    logic [TW-1:0]               now_reg;

    // Channel memories and their valid bits
    logic [FW-1:0]               duty_mem [CHANNELS];
    mdfr_pkg::time_entry_t       time_mem [CHANNELS];
    logic [CHANNELS-1:0]         duty_vld_reg;
    logic [CHANNELS-1:0]         time_vld_reg;
    logic [FW-1:0]               duty_rd_reg;
    mdfr_pkg::time_entry_t       time_rd_reg;
    logic                        duty_rd_vld_reg;
    logic                        time_rd_vld_reg;

    // Demo path
    logic [TW-1:0]               scale_reg;
    logic [IDX_W-1:0]            idx_reg;
    logic [FW-1:0]               rom_data;
    logic                        div_done;
    logic [TW-1:0]               div_quo;
    logic [mdfr_pkg::REM_W-1:0]  div_rem;
    logic [TW-1:0]               div_num;

    // Code scaling and output stages
    logic [FW-1:0]               new_duty_reg;
    logic [PW-1:0]               prod_reg;
    logic [PW:0]                 code_sum_c;
    logic [DUTY_BITS-1:0]        code_c;
    logic                        hold_valid_reg;
    logic [CH_W-1:0]             hold_ch_reg;
    logic [DUTY_BITS-1:0]        hold_code_reg;
    logic                        m_tvalid_reg;
    logic [CH_W-1:0]             out_ch_reg;
    logic [DUTY_BITS-1:0]        out_code_reg;
    logic                        out_last_reg;

    // Channel update logic
    logic [FW-1:0]               step_tbl [mdfr_pkg::STEP_TBL_DEPTH];
    logic [FW-1:0]               cur_c;
    logic [FW-1:0]               tgt_c;
    mdfr_pkg::time_entry_t       te_c;
    logic [TW-1:0]               dt_c;
    logic [FW-1:0]               dv_c;
    logic [FW:0]                 up_c;
    logic [FW:0]                 dn_lim_c;
    logic [FW-1:0]               calc_duty_new;
    logic                        calc_emit;
    logic                        calc_time_we;
    mdfr_pkg::time_entry_t       calc_time_wd;

    // Sequencer controls
    logic                        last_ch;
    logic                        out_free;
    logic                        mem_rd;
    logic                        duty_we;
    logic [FW-1:0]               duty_wd;
    logic                        time_we;
    logic                        div_start;
    logic                        hold_load;
    logic                        hold_clear;
    logic                        out_push;
    logic                        out_last;
    logic                        ch_adv;

    // ---------------- step size table ----------------
    for (genvar gi = 0; gi < mdfr_pkg::STEP_TBL_DEPTH; gi++) begin : g_step
        localparam logic [FW-1:0] STEP_VAL = mdfr_pkg::step_entry(gi);
        assign step_tbl[gi] = STEP_VAL;
    end

    // ---------------- configuration ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= mdfr_pkg::MODE_FADE;
            for (int i = 0; i < CHANNELS; i++) begin
                target_reg[i] <= '0;
            end
        end else if (cfg_wr_en) begin
            if (cfg_addr == CFG_AW'(mdfr_pkg::REG_MODE)) begin
                mode_reg <= cfg_wdata[mdfr_pkg::MODE_W-1:0];
            end else if (cfg_addr <= CFG_AW'(CHANNELS)) begin
                target_reg[CH_W'(cfg_addr - CFG_AW'(mdfr_pkg::REG_TARGET0))] <= cfg_wdata;
            end
        end
    end

    // ---------------- channel update ----------------
    // Fade mode is follow mode with a zero target.
    always_comb begin
        cur_c         = duty_rd_vld_reg ? duty_rd_reg : '0;
        te_c          = time_rd_vld_reg ? time_rd_reg : '0;
        tgt_c         = (mode_reg == mdfr_pkg::MODE_FOLLOW) ? target_reg[ch_reg] : '0;
        dt_c          = now_reg - te_c.start;
        dv_c          = (|dt_c[TW-1:SIW]) ? FULL : step_tbl[dt_c[SIW-1:0]];
        up_c          = {1'b0, cur_c} + {1'b0, dv_c};
        dn_lim_c      = {1'b0, tgt_c} + {1'b0, dv_c};
        calc_emit     = 1'b0;
        calc_time_we  = 1'b0;
        calc_time_wd  = '{started: 1'b1, start: now_reg};
        calc_duty_new = tgt_c;
        if (cur_c == tgt_c) begin
            // settled: drop the started flag, keep the start time
            calc_time_we = 1'b1;
            calc_time_wd = '{started: 1'b0, start: te_c.start};
        end else if (!te_c.started) begin
            // first tick of a ramp only arms the timer
            calc_time_we = 1'b1;
        end else if (dv_c != '0) begin
            calc_emit    = 1'b1;
            calc_time_we = 1'b1;
            if (cur_c < tgt_c && up_c < {1'b0, tgt_c}) begin
                calc_duty_new = up_c[FW-1:0];
            end else if (cur_c > tgt_c && {1'b0, cur_c} > dn_lim_c) begin
                calc_duty_new = cur_c - dv_c;
            end
        end
    end

    // ---------------- sequencer: next state ----------------
    assign last_ch  = (ch_reg == CH_W'(CHANNELS - 1));
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mdfr_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    case (mode_reg)
                        mdfr_pkg::MODE_FADE,
                        mdfr_pkg::MODE_FOLLOW: state_next = mdfr_pkg::S_READ;
                        mdfr_pkg::MODE_DEMO:   state_next = mdfr_pkg::S_MOD_RUN;
                        default:               state_next = mdfr_pkg::S_IDLE;
                    endcase
                end
            end
            mdfr_pkg::S_READ: state_next = mdfr_pkg::S_CALC;
            mdfr_pkg::S_CALC: begin
                if (calc_emit) begin
                    state_next = mdfr_pkg::S_MUL;
                end else if (last_ch) begin
                    state_next = mdfr_pkg::S_FLUSH;
                end else begin
                    state_next = mdfr_pkg::S_READ;
                end
            end
            mdfr_pkg::S_MUL: state_next = mdfr_pkg::S_CODE;
            mdfr_pkg::S_CODE: begin
                if (!hold_valid_reg || out_free) begin
                    if (mode_reg == mdfr_pkg::MODE_DEMO || last_ch) begin
                        state_next = mdfr_pkg::S_FLUSH;
                    end else begin
                        state_next = mdfr_pkg::S_READ;
                    end
                end
            end
            mdfr_pkg::S_FLUSH: begin
                if (!hold_valid_reg || out_free) begin
                    state_next = mdfr_pkg::S_IDLE;
                end
            end
            mdfr_pkg::S_MOD_RUN: begin
                if (div_done) begin
                    state_next = mdfr_pkg::S_SCALE;
                end
            end
            mdfr_pkg::S_SCALE: state_next = mdfr_pkg::S_QUO_RUN;
            mdfr_pkg::S_QUO_RUN: begin
                if (div_done) begin
                    state_next = mdfr_pkg::S_ROM;
                end
            end
            mdfr_pkg::S_ROM:     state_next = mdfr_pkg::S_DEMO_WR;
            mdfr_pkg::S_DEMO_WR: state_next = mdfr_pkg::S_MUL;
            default:             state_next = mdfr_pkg::S_IDLE;
        endcase
    end

    // ---------------- sequencer: outputs ----------------
    always_comb begin
        s_tready   = (state_reg == mdfr_pkg::S_IDLE);
        mem_rd     = (state_reg == mdfr_pkg::S_READ);
        duty_we    = ((state_reg == mdfr_pkg::S_CALC) && calc_emit)
                     || (state_reg == mdfr_pkg::S_DEMO_WR);
        duty_wd    = (state_reg == mdfr_pkg::S_DEMO_WR) ? rom_data : calc_duty_new;
        time_we    = (state_reg == mdfr_pkg::S_CALC) && calc_time_we;
        div_start  = ((state_reg == mdfr_pkg::S_IDLE) && s_tvalid
                      && (mode_reg == mdfr_pkg::MODE_DEMO))
                     || (state_reg == mdfr_pkg::S_SCALE);
        div_num    = (state_reg == mdfr_pkg::S_SCALE) ? scale_reg : s_tdata;
        hold_load  = (state_reg == mdfr_pkg::S_CODE) && (!hold_valid_reg || out_free);
        hold_clear = (state_reg == mdfr_pkg::S_FLUSH) && hold_valid_reg && out_free;
        out_push   = (hold_load && hold_valid_reg) || hold_clear;
        out_last   = (state_reg == mdfr_pkg::S_FLUSH);
        ch_adv     = (state_next == mdfr_pkg::S_READ) && (state_reg != mdfr_pkg::S_IDLE);
    end

    // ---------------- control registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= mdfr_pkg::S_IDLE;
            duty_vld_reg   <= '0;
            time_vld_reg   <= '0;
            hold_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (duty_we) begin
                duty_vld_reg[ch_reg] <= 1'b1;
            end
            if (time_we) begin
                time_vld_reg[ch_reg] <= 1'b1;
            end
            if (hold_load) begin
                hold_valid_reg <= 1'b1;
            end else if (hold_clear) begin
                hold_valid_reg <= 1'b0;
            end
            if (out_push) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // ---------------- channel memories ----------------
    // One entry in flight at a time, so a read never meets a pending write.
    always_ff @(posedge aclk) begin
        if (duty_we) begin
            duty_mem[ch_reg] <= duty_wd;
        end
        if (time_we) begin
            time_mem[ch_reg] <= calc_time_wd;
        end
        if (mem_rd) begin
            duty_rd_reg     <= duty_mem[ch_reg];
            time_rd_reg     <= time_mem[ch_reg];
            duty_rd_vld_reg <= duty_vld_reg[ch_reg];
            time_rd_vld_reg <= time_vld_reg[ch_reg];
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            now_reg <= s_tdata;
            ch_reg  <= '0;
        end else if (ch_adv) begin
            ch_reg <= ch_reg + 1'b1;
        end
        if ((state_reg == mdfr_pkg::S_MOD_RUN) && div_done) begin
            scale_reg <= TW'(div_rem) * TW'(DEMO_TABLE_DEPTH);
        end
        if ((state_reg == mdfr_pkg::S_QUO_RUN) && div_done) begin
            idx_reg <= (div_quo >= TW'(DEMO_TABLE_DEPTH)) ? IDX_W'(DEMO_TABLE_DEPTH - 1)
                                                           : div_quo[IDX_W-1:0];
        end
        if (duty_we) begin
            new_duty_reg <= duty_wd;
        end
        if (state_reg == mdfr_pkg::S_MUL) begin
            prod_reg <= PW'(new_duty_reg) * DUTY_MAX;
        end
        if (hold_load) begin
            hold_ch_reg   <= ch_reg;
            hold_code_reg <= code_c;
        end
        if (out_push) begin
            out_ch_reg   <= hold_ch_reg;
            out_code_reg <= hold_code_reg;
            out_last_reg <= out_last;
        end
    end

    // floor(x / 65535) as (x + (x >> 16) + 1) >> 16, exact below 2^32
    assign code_sum_c = {1'b0, prod_reg} + (PW + 1)'(prod_reg >> FW) + (PW + 1)'(1);
    assign code_c     = code_sum_c[FW +: DUTY_BITS];

    // ---------------- demo helpers ----------------
    mdfr_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .done    (div_done),
        .quo     (div_quo),
        .rem     (div_rem)
    );

    mdfr_demo_rom #(
        .DEPTH (DEMO_TABLE_DEPTH)
    ) u_rom (
        .aclk    (aclk),
        .rd_en   (state_reg == mdfr_pkg::S_ROM),
        .idx     (idx_reg),
        .rd_data (rom_data)
    );

    // ---------------- ports ----------------
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_TW'({out_code_reg, out_ch_reg});
    assign m_tlast  = out_last_reg;

`ifndef ASSERT_OFF
    // Every tick drains its held result before the next one is taken
    a_idle_hold_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mdfr_pkg::S_IDLE) |-> !hold_valid_reg)
        else $error("held result left over between ticks");

    // Divider only finishes while the sequencer waits for it
    a_div_done_expected: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == mdfr_pkg::S_MOD_RUN || state_reg == mdfr_pkg::S_QUO_RUN))
        else $error("divider finished outside a wait state");

    // A duty write marks its entry valid
    a_duty_write_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        duty_we |=> duty_vld_reg[$past(ch_reg)])
        else $error("duty entry not marked valid after write");

    // A duty step always restarts that channel's timer
    a_emit_restarts_timer: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mdfr_pkg::S_CALC && calc_emit) |-> time_we)
        else $error("duty step without timer update");
`endif

endmodule
